>>> rtl/lrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lrc_pkg;

   localparam int COORD_BITS    = 32;
   localparam int PROD_BITS     = 2 * COORD_BITS;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 4;
   localparam int QUEUE_DEPTH   = 4;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic        [COORD_BITS-1:0] mag_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   localparam coord_type RESET_X_MIN = -coord_type'(65536);
   localparam coord_type RESET_X_MAX = coord_type'(65536);
   localparam coord_type RESET_Y_MIN = -coord_type'(65536);
   localparam coord_type RESET_Y_MAX = coord_type'(65536);

   typedef enum logic [1:0] {
      REG_X_MIN = 2'd0,
      REG_X_MAX = 2'd1,
      REG_Y_MIN = 2'd2,
      REG_Y_MAX = 2'd3
   } reg_index_type;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } req_type;

   typedef struct packed {
      logic      visible;
      coord_type clip_start_x;
      coord_type clip_start_y;
      coord_type clip_end_x;
      coord_type clip_end_y;
   } rsp_type;

   typedef struct packed {
      coord_type x_min;
      coord_type x_max;
      coord_type y_min;
      coord_type y_max;
   } window_type;

   // A classified segment: ordered along the major axis, window edges mapped to match.
   typedef struct packed {
      logic      reject;
      logic      swap_axes;
      logic      swap_ends;
      coord_type a1;
      coord_type b1;
      coord_type a2;
      coord_type b2;
      coord_type a_min;
      coord_type a_max;
      coord_type b_min;
      coord_type b_max;
      mag_type   da;
      mag_type   db;
      logic      db_neg;
   } seg_type;

   function automatic mag_type diff_mag(coord_type a, coord_type b);
      logic signed [COORD_BITS:0] d;
      logic signed [COORD_BITS:0] n;
      d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
      n = -d;
      return d[COORD_BITS] ? n[COORD_BITS-1:0] : d[COORD_BITS-1:0];
   endfunction

   function automatic logic diff_neg(coord_type a, coord_type b);
      return a < b;
   endfunction

endpackage

`default_nettype wire

>>> rtl/line_rectangle_clipper_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Clips line segments in signed Q16.16 against the window held in four registers
// (x_min, x_max, y_min, y_max at byte addresses 0, 4, 8 and 12). The front end
// classifies a segment in the cycle it is pushed and takes one segment per clock,
// while the queue is not full, into a four-entry queue. The back end then works
// each segment through one shared shift-add multiplier and one restoring divider.
// A trivially rejected segment or a wholly inside one uses neither of them.
// Clipping a major-axis edge or the far minor edge takes one product and one
// division, and clipping the near minor edge takes two products before its
// division. The back end therefore sets the sustained rate. A finished result
// waits in an output register while the next segment is worked on.
module line_rectangle_clipper_top
   import lrc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  req_type                  req_data,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output rsp_type                  rsp_data,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   window_type    win_ff, win_in;
   reg_index_type reg_index;
   logic          csr_write;
   seg_type       front_seg, queue_seg;
   logic          queue_empty, queue_pop;

   assign csr_pready = 1'b1;
   assign reg_index  = reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      win_in = win_ff;
      if (csr_write) begin
         case (reg_index)
            REG_X_MIN: win_in.x_min = coord_type'(csr_pwdata);
            REG_X_MAX: win_in.x_max = coord_type'(csr_pwdata);
            REG_Y_MIN: win_in.y_min = coord_type'(csr_pwdata);
            REG_Y_MAX: win_in.y_max = coord_type'(csr_pwdata);
            default:   win_in = win_ff;
         endcase
      end
      case (reg_index)
         REG_X_MIN: csr_prdata = CSR_DATA_BITS'(win_ff.x_min);
         REG_X_MAX: csr_prdata = CSR_DATA_BITS'(win_ff.x_max);
         REG_Y_MIN: csr_prdata = CSR_DATA_BITS'(win_ff.y_min);
         REG_Y_MAX: csr_prdata = CSR_DATA_BITS'(win_ff.y_max);
         default:   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff.x_min <= RESET_X_MIN;
         win_ff.x_max <= RESET_X_MAX;
         win_ff.y_min <= RESET_Y_MIN;
         win_ff.y_max <= RESET_Y_MAX;
      end else begin
         win_ff <= win_in;
      end
   end

   lrc_front u_front (
      .win (win_ff),
      .req (req_data),
      .seg (front_seg)
   );

   lrc_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (front_seg),
      .full    (req_full),
      .pop     (queue_pop),
      .rd_data (queue_seg),
      .empty   (queue_empty)
   );

   lrc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_empty  (queue_empty),
      .in_data   (queue_seg),
      .in_pop    (queue_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop)
   );

   // A hidden segment carries all-zero coordinates.
   a_hidden_zero : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.visible) |->
         (rsp_data.clip_start_x == '0 && rsp_data.clip_start_y == '0 &&
          rsp_data.clip_end_x == '0 && rsp_data.clip_end_y == '0))
      else $error("hidden segment with non-zero coordinates");

   // After reset the output register is empty and the queue is not full.
   a_reset_clear : assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

endmodule

`default_nettype wire

>>> rtl/lrc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lrc_front
   import lrc_pkg::*;
(
   input  window_type win,
   input  req_type    req,
   output seg_type    seg
);

   mag_type   dx, dy;
   logic      swap_axes, swap_ends;
   coord_type pa1, pb1, pa2, pb2;

   always_comb begin
      dx = diff_mag(req.end_x, req.start_x);
      dy = diff_mag(req.end_y, req.start_y);
      swap_axes = dx < dy;

      pa1 = swap_axes ? req.start_y : req.start_x;
      pb1 = swap_axes ? req.start_x : req.start_y;
      pa2 = swap_axes ? req.end_y : req.end_x;
      pb2 = swap_axes ? req.end_x : req.end_y;
      swap_ends = pa2 < pa1;

      seg.reject = (req.start_x < win.x_min && req.end_x < win.x_min) ||
                   (req.start_x > win.x_max && req.end_x > win.x_max) ||
                   (req.start_y < win.y_min && req.end_y < win.y_min) ||
                   (req.start_y > win.y_max && req.end_y > win.y_max);
      seg.swap_axes = swap_axes;
      seg.swap_ends = swap_ends;
      seg.a1 = swap_ends ? pa2 : pa1;
      seg.b1 = swap_ends ? pb2 : pb1;
      seg.a2 = swap_ends ? pa1 : pa2;
      seg.b2 = swap_ends ? pb1 : pb2;
      seg.a_min = swap_axes ? win.y_min : win.x_min;
      seg.a_max = swap_axes ? win.y_max : win.x_max;
      seg.b_min = swap_axes ? win.x_min : win.y_min;
      seg.b_max = swap_axes ? win.x_max : win.y_max;
      seg.da = diff_mag(seg.a2, seg.a1);
      seg.db = diff_mag(seg.b2, seg.b1);
      seg.db_neg = diff_neg(seg.b2, seg.b1);
   end

endmodule

`default_nettype wire

>>> rtl/lrc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module lrc_fifo
   import lrc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  seg_type wr_data,
   output logic    full,
   input  logic    pop,
   output seg_type rd_data,
   output logic    empty
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   seg_type             mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = count_ff == CNT_BITS'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

>>> rtl/lrc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lrc_back
   import lrc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_empty,
   input  seg_type in_data,
   output logic    in_pop,
   output logic    rsp_empty,
   output rsp_type rsp_data,
   input  logic    rsp_pop
);

   localparam int N         = COORD_BITS;
   localparam int CNT_BITS  = $clog2(PROD_BITS);
   localparam int WIDE_BITS = PROD_BITS + 2;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_EDGE = 7'b0000010,
      ST_MUL  = 7'b0000100,
      ST_DIV  = 7'b0001000,
      ST_CMP  = 7'b0010000,
      ST_FIX  = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   typedef enum logic [3:0] {
      STEP_MAJOR_LO = 4'b0001,
      STEP_MINOR_LO = 4'b0010,
      STEP_MAJOR_HI = 4'b0100,
      STEP_MINOR_HI = 4'b1000
   } step_type;

   typedef enum logic [1:0] {
      MODE_OFS  = 2'd0,
      MODE_CMP1 = 2'd1,
      MODE_CMP2 = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      DST_A1 = 2'd0,
      DST_B1 = 2'd1,
      DST_A2 = 2'd2,
      DST_B2 = 2'd3
   } dest_type;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   mode_type  mode_ff, mode_in;
   dest_type  dest_ff, dest_in;
   seg_type   seg_ff, seg_in;
   coord_type a1_ff, a1_in, b1_ff, b1_in, a2_ff, a2_in, b2_ff, b2_in;
   logic      vis_ff, vis_in;
   coord_type op_base_ff, op_base_in;
   logic      op_neg_ff, op_neg_in;
   mag_type   op_d_ff, op_d_in;
   mag_type   mul_a_ff, mul_a_in;
   mag_type   rem_ff, rem_in;
   logic [PROD_BITS-1:0]       prod_ff, prod_in;
   logic [CNT_BITS-1:0]        cnt_ff, cnt_in;
   logic signed [PROD_BITS:0]  p1_ff, p1_in;
   logic      out_valid_ff, out_valid_in;
   rsp_type   out_data_ff, out_data_in;

   // Operation launch bundle.
   logic      st_en;
   mode_type  st_mode;
   coord_type st_base;
   logic      st_neg;
   mag_type   st_ma, st_mb, st_d;
   dest_type  st_dest;

   logic      pos_b, neg_b, cmp_reject, rnd_up;
   coord_type lo_edge, hi_edge, fix_val;
   logic [N:0]                 msum, dsh, dsub;
   logic                       dge;
   logic [PROD_BITS:0]         qr;
   logic signed [PROD_BITS:0]  prod_s;
   logic signed [WIDE_BITS-1:0] base_w, sum_w, max_w, min_w;
   coord_type o_a1, o_b1, o_a2, o_b2;
   rsp_type   mapped;

   always_comb begin
      pos_b   = !seg_ff.db_neg && (seg_ff.db != '0);
      neg_b   = seg_ff.db_neg && (seg_ff.db != '0);
      lo_edge = pos_b ? seg_ff.b_min : seg_ff.b_max;
      hi_edge = neg_b ? seg_ff.b_min : seg_ff.b_max;

      // Shift-add multiply: the low half of prod holds the multiplier at the start.
      msum = {1'b0, prod_ff[PROD_BITS-1:N]} + (prod_ff[0] ? {1'b0, mul_a_ff} : '0);

      // Restoring divide: prod shifts the dividend out and the quotient in.
      dsh  = {rem_ff, prod_ff[PROD_BITS-1]};
      dge  = dsh >= {1'b0, op_d_ff};
      dsub = dsh - {1'b0, op_d_ff};

      // Round half away from zero on the magnitude, then apply the sign and saturate.
      rnd_up = {rem_ff, 1'b0} >= {1'b0, op_d_ff};
      qr     = {1'b0, prod_ff} + {{PROD_BITS{1'b0}}, rnd_up};
      base_w = {{(WIDE_BITS-N){op_base_ff[N-1]}}, op_base_ff};
      max_w  = {{(WIDE_BITS-N){1'b0}}, COORD_MAX};
      min_w  = {{(WIDE_BITS-N){1'b1}}, COORD_MIN};
      sum_w  = op_neg_ff ? base_w - $signed({1'b0, qr}) : base_w + $signed({1'b0, qr});
      if (op_d_ff == '0) begin
         fix_val = op_base_ff;
      end else if (sum_w > max_w) begin
         fix_val = COORD_MAX;
      end else if (sum_w < min_w) begin
         fix_val = COORD_MIN;
      end else begin
         fix_val = sum_w[N-1:0];
      end

      prod_s     = op_neg_ff ? -$signed({1'b0, prod_ff}) : $signed({1'b0, prod_ff});
      cmp_reject = pos_b ? (p1_ff < prod_s) : (p1_ff > prod_s);

      o_a1 = seg_ff.swap_ends ? a2_ff : a1_ff;
      o_b1 = seg_ff.swap_ends ? b2_ff : b1_ff;
      o_a2 = seg_ff.swap_ends ? a1_ff : a2_ff;
      o_b2 = seg_ff.swap_ends ? b1_ff : b2_ff;
      mapped.visible = vis_ff;
      if (!vis_ff) begin
         mapped.clip_start_x = '0;
         mapped.clip_start_y = '0;
         mapped.clip_end_x   = '0;
         mapped.clip_end_y   = '0;
      end else if (seg_ff.swap_axes) begin
         mapped.clip_start_x = o_b1;
         mapped.clip_start_y = o_a1;
         mapped.clip_end_x   = o_b2;
         mapped.clip_end_y   = o_a2;
      end else begin
         mapped.clip_start_x = o_a1;
         mapped.clip_start_y = o_b1;
         mapped.clip_end_x   = o_a2;
         mapped.clip_end_y   = o_b2;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      mode_in      = mode_ff;
      dest_in      = dest_ff;
      seg_in       = seg_ff;
      a1_in        = a1_ff;
      b1_in        = b1_ff;
      a2_in        = a2_ff;
      b2_in        = b2_ff;
      vis_in       = vis_ff;
      op_base_in   = op_base_ff;
      op_neg_in    = op_neg_ff;
      op_d_in      = op_d_ff;
      mul_a_in     = mul_a_ff;
      rem_in       = rem_ff;
      prod_in      = prod_ff;
      cnt_in       = cnt_ff;
      p1_in        = p1_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      in_pop       = 1'b0;
      st_en        = 1'b0;
      st_mode      = MODE_OFS;
      st_base      = '0;
      st_neg       = 1'b0;
      st_ma        = '0;
      st_mb        = '0;
      st_d         = '0;
      st_dest      = DST_A1;

      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (!in_empty) begin
               in_pop   = 1'b1;
               seg_in   = in_data;
               a1_in    = in_data.a1;
               b1_in    = in_data.b1;
               a2_in    = in_data.a2;
               b2_in    = in_data.b2;
               step_in  = STEP_MAJOR_LO;
               vis_in   = !in_data.reject;
               state_in = in_data.reject ? ST_OUT : ST_EDGE;
            end
         end
         ST_EDGE: begin
            case (step_ff)
               STEP_MAJOR_LO: begin
                  if (a1_ff < seg_ff.a_min) begin
                     a1_in   = seg_ff.a_min;
                     st_en   = 1'b1;
                     st_base = b2_ff;
                     st_neg  = seg_ff.db_neg ^ diff_neg(seg_ff.a_min, a2_ff);
                     st_ma   = seg_ff.db;
                     st_mb   = diff_mag(seg_ff.a_min, a2_ff);
                     st_d    = seg_ff.da;
                     st_dest = DST_B1;
                  end else begin
                     step_in = STEP_MINOR_LO;
                  end
               end
               STEP_MINOR_LO: begin
                  if (pos_b ? (b1_ff > seg_ff.b_max) : (b1_ff < seg_ff.b_min)) begin
                     vis_in   = 1'b0;
                     state_in = ST_OUT;
                  end else if (pos_b ? (b1_ff < seg_ff.b_min) : (b1_ff > seg_ff.b_max)) begin
                     // The segment must still reach the edge before the far end of the window.
                     st_en   = 1'b1;
                     st_mode = MODE_CMP1;
                     st_neg  = seg_ff.db_neg ^ diff_neg(seg_ff.a_max, a2_ff);
                     st_ma   = seg_ff.db;
                     st_mb   = diff_mag(seg_ff.a_max, a2_ff);
                  end else begin
                     step_in = STEP_MAJOR_HI;
                  end
               end
               STEP_MAJOR_HI: begin
                  if (a2_ff > seg_ff.a_max) begin
                     a2_in   = seg_ff.a_max;
                     st_en   = 1'b1;
                     st_base = b1_ff;
                     st_neg  = seg_ff.db_neg ^ diff_neg(seg_ff.a_max, a1_ff);
                     st_ma   = seg_ff.db;
                     st_mb   = diff_mag(seg_ff.a_max, a1_ff);
                     st_d    = seg_ff.da;
                     st_dest = DST_B2;
                  end else begin
                     step_in = STEP_MINOR_HI;
                  end
               end
               STEP_MINOR_HI: begin
                  if (neg_b ? (b2_ff < seg_ff.b_min) : (b2_ff > seg_ff.b_max)) begin
                     b2_in   = hi_edge;
                     st_en   = 1'b1;
                     st_base = a1_ff;
                     st_neg  = seg_ff.db_neg ^ diff_neg(hi_edge, b1_ff);
                     st_ma   = seg_ff.da;
                     st_mb   = diff_mag(hi_edge, b1_ff);
                     st_d    = seg_ff.db;
                     st_dest = DST_A2;
                  end else begin
                     state_in = ST_OUT;
                  end
               end
               default: begin
                  state_in = ST_OUT;
               end
            endcase
         end
         ST_MUL: begin
            prod_in = {msum, prod_ff[N-1:1]};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(N - 1)) begin
               cnt_in   = '0;
               rem_in   = '0;
               state_in = (mode_ff == MODE_OFS) ? ST_DIV : ST_CMP;
            end
         end
         ST_DIV: begin
            prod_in = {prod_ff[PROD_BITS-2:0], dge};
            rem_in  = dge ? dsub[N-1:0] : dsh[N-1:0];
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(PROD_BITS - 1)) begin
               cnt_in   = '0;
               state_in = ST_FIX;
            end
         end
         ST_CMP: begin
            case (mode_ff)
               MODE_CMP1: begin
                  p1_in   = prod_s;
                  st_en   = 1'b1;
                  st_mode = MODE_CMP2;
                  st_neg  = diff_neg(lo_edge, b2_ff);
                  st_ma   = seg_ff.da;
                  st_mb   = diff_mag(lo_edge, b2_ff);
               end
               MODE_CMP2: begin
                  if (cmp_reject) begin
                     vis_in   = 1'b0;
                     state_in = ST_OUT;
                  end else begin
                     // The second product is already the numerator of the new major coordinate.
                     b1_in      = lo_edge;
                     op_base_in = a2_ff;
                     op_neg_in  = op_neg_ff ^ seg_ff.db_neg;
                     op_d_in    = seg_ff.db;
                     dest_in    = DST_A1;
                     mode_in    = MODE_OFS;
                     rem_in     = '0;
                     cnt_in     = '0;
                     state_in   = (seg_ff.db == '0) ? ST_FIX : ST_DIV;
                  end
               end
               default: begin
                  state_in = ST_OUT;
               end
            endcase
         end
         ST_FIX: begin
            case (dest_ff)
               DST_A1:  a1_in = fix_val;
               DST_B1:  b1_in = fix_val;
               DST_A2:  a2_in = fix_val;
               DST_B2:  b2_in = fix_val;
               default: a1_in = fix_val;
            endcase
            state_in = ST_EDGE;
            case (step_ff)
               STEP_MAJOR_LO: step_in = STEP_MINOR_LO;
               STEP_MINOR_LO: step_in = STEP_MAJOR_HI;
               STEP_MAJOR_HI: step_in = STEP_MINOR_HI;
               default:       state_in = ST_OUT;
            endcase
         end
         ST_OUT: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in = 1'b1;
               out_data_in  = mapped;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (st_en) begin
         mode_in    = st_mode;
         dest_in    = st_dest;
         op_base_in = st_base;
         op_neg_in  = st_neg;
         op_d_in    = st_d;
         mul_a_in   = st_ma;
         prod_in    = {{N{1'b0}}, st_mb};
         cnt_in     = '0;
         state_in   = (st_mode == MODE_OFS && st_d == '0) ? ST_FIX : ST_MUL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_MAJOR_LO;
         mode_ff      <= MODE_OFS;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         mode_ff      <= mode_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dest_ff     <= dest_in;
      seg_ff      <= seg_in;
      a1_ff       <= a1_in;
      b1_ff       <= b1_in;
      a2_ff       <= a2_in;
      b2_ff       <= b2_in;
      vis_ff      <= vis_in;
      op_base_ff  <= op_base_in;
      op_neg_ff   <= op_neg_in;
      op_d_ff     <= op_d_in;
      mul_a_ff    <= mul_a_in;
      rem_ff      <= rem_in;
      prod_ff     <= prod_in;
      p1_ff       <= p1_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import lrc_pkg::*;

   typedef logic signed [127:0] wide_type;

   localparam int  ONE        = 65536;
   localparam int  CYCLE_CAP  = 4_000_000;
   localparam int  DRAIN_WAIT = 600;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_push = 1'b0;
   logic                     req_full;
   req_type                  req_data = '0;
   logic                     rsp_empty;
   logic                     rsp_pop = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   line_rectangle_clipper_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   coord_type win_x_min = RESET_X_MIN;
   coord_type win_x_max = RESET_X_MAX;
   coord_type win_y_min = RESET_Y_MIN;
   coord_type win_y_max = RESET_Y_MAX;

   req_type pending_segs[$];
   rsp_type clipped_segs[$];
   int      send_idle = 0;
   int      recv_idle = 0;
   int      fail_count = 0;
   longint  cycle_count = 0;

   // base + round(p*q/d), ties away from zero, saturated to the coordinate range.
   function automatic coord_type intercept(wide_type base, wide_type p, wide_type q,
                                           wide_type d);
      wide_type num, n, dm, quo, rem, res;
      if (d == 0) return coord_type'(base);
      num = p * q;
      n   = (num < 0) ? -num : num;
      dm  = (d < 0) ? -d : d;
      quo = n / dm;
      rem = n % dm;
      if (rem >= dm - rem) quo = quo + 1;
      res = (((num < 0) != (d < 0)) && num != 0) ? base - quo : base + quo;
      if (res > wide_type'(COORD_MAX)) res = wide_type'(COORD_MAX);
      if (res < wide_type'(COORD_MIN)) res = wide_type'(COORD_MIN);
      return coord_type'(res);
   endfunction

   function automatic rsp_type clip_segment(req_type s);
      wide_type x1, y1, x2, y2, a1, b1, a2, b2, amin, amax, bmin, bmax, t, da, db;
      wide_type dx, dy;
      logic swap_axes, swap_ends;
      rsp_type r;
      r  = '0;
      x1 = s.start_x; y1 = s.start_y; x2 = s.end_x; y2 = s.end_y;
      if ((x1 < win_x_min && x2 < win_x_min) || (x1 > win_x_max && x2 > win_x_max) ||
          (y1 < win_y_min && y2 < win_y_min) || (y1 > win_y_max && y2 > win_y_max))
         return r;
      dx = x2 - x1; dy = y2 - y1;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      swap_axes = dx < dy;
      if (swap_axes) begin
         a1 = y1; b1 = x1; a2 = y2; b2 = x2;
         amin = win_y_min; amax = win_y_max; bmin = win_x_min; bmax = win_x_max;
      end else begin
         a1 = x1; b1 = y1; a2 = x2; b2 = y2;
         amin = win_x_min; amax = win_x_max; bmin = win_y_min; bmax = win_y_max;
      end
      swap_ends = a2 < a1;
      if (swap_ends) begin
         t = a1; a1 = a2; a2 = t;
         t = b1; b1 = b2; b2 = t;
      end
      da = a2 - a1;
      db = b2 - b1;
      if (a1 < amin) begin
         a1 = amin;
         b1 = intercept(b2, db, amin - a2, da);
      end
      if (db > 0) begin
         if (b1 > bmax) return r;
         if (b1 < bmin) begin
            if (db * (amax - a2) < (bmin - b2) * da) return r;
            b1 = bmin;
            a1 = intercept(a2, da, bmin - b2, db);
         end
      end else begin
         if (b1 < bmin) return r;
         if (b1 > bmax) begin
            if (db * (amax - a2) > (bmax - b2) * da) return r;
            b1 = bmax;
            a1 = intercept(a2, da, bmax - b2, db);
         end
      end
      if (a2 > amax) begin
         a2 = amax;
         b2 = intercept(b1, db, amax - a1, da);
      end
      if (db < 0) begin
         if (b2 < bmin) begin
            b2 = bmin;
            a2 = intercept(a1, da, bmin - b1, db);
         end
      end else if (b2 > bmax) begin
         b2 = bmax;
         a2 = intercept(a1, da, bmax - b1, db);
      end
      if (swap_ends) begin
         t = a1; a1 = a2; a2 = t;
         t = b1; b1 = b2; b2 = t;
      end
      r.visible = 1'b1;
      if (swap_axes) begin
         r.clip_start_x = coord_type'(b1); r.clip_start_y = coord_type'(a1);
         r.clip_end_x   = coord_type'(b2); r.clip_end_y   = coord_type'(a2);
      end else begin
         r.clip_start_x = coord_type'(a1); r.clip_start_y = coord_type'(b1);
         r.clip_end_x   = coord_type'(a2); r.clip_end_y   = coord_type'(b2);
      end
      return r;
   endfunction

   // Driver: a segment stays on the port until its transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            clipped_segs.push_back(clip_segment(req_data));
            void'(pending_segs.pop_front());
         end
         if (!(req_push && req_full)) begin
            if (pending_segs.size() > 0 && $urandom_range(99) >= send_idle) begin
               req_push <= 1'b1;
               req_data <= pending_segs[0];
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result transfer against the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (clipped_segs.size() == 0) begin
            $error("unexpected result transfer");
            fail_count = fail_count + 1;
         end else begin
            want = clipped_segs.pop_front();
            if (rsp_data.visible !== want.visible) begin
               $error("visible: expected %0d, got %0d", want.visible, rsp_data.visible);
               fail_count = fail_count + 1;
            end
            if (rsp_data.clip_start_x !== want.clip_start_x) begin
               $error("clip_start_x: expected %0d, got %0d", want.clip_start_x,
                      rsp_data.clip_start_x);
               fail_count = fail_count + 1;
            end
            if (rsp_data.clip_start_y !== want.clip_start_y) begin
               $error("clip_start_y: expected %0d, got %0d", want.clip_start_y,
                      rsp_data.clip_start_y);
               fail_count = fail_count + 1;
            end
            if (rsp_data.clip_end_x !== want.clip_end_x) begin
               $error("clip_end_x: expected %0d, got %0d", want.clip_end_x,
                      rsp_data.clip_end_x);
               fail_count = fail_count + 1;
            end
            if (rsp_data.clip_end_y !== want.clip_end_y) begin
               $error("clip_end_y: expected %0d, got %0d", want.clip_end_y,
                      rsp_data.clip_end_y);
               fail_count = fail_count + 1;
            end
         end
      end
      rsp_pop <= !reset && ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_CAP) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic add_seg(int x1, int y1, int x2, int y2);
      req_type s;
      s.start_x = x1; s.start_y = y1; s.end_x = x2; s.end_y = y2;
      pending_segs.push_back(s);
   endtask

   task automatic write_reg(reg_index_type idx, coord_type value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'(4 * idx);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_X_MIN: win_x_min = value;
         REG_X_MAX: win_x_max = value;
         REG_Y_MIN: win_y_min = value;
         REG_Y_MAX: win_y_max = value;
         default: ;
      endcase
   endtask

   task automatic set_window(coord_type xl, coord_type xh, coord_type yl, coord_type yh);
      write_reg(REG_X_MIN, xl);
      write_reg(REG_X_MAX, xh);
      write_reg(REG_Y_MIN, yl);
      write_reg(REG_Y_MAX, yh);
   endtask

   task automatic drain();
      while (pending_segs.size() > 0 || clipped_segs.size() > 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // Mostly coordinates around the window, with edges, extremes and raw noise mixed in.
   function automatic int pick_coord(longint lo, longint hi);
      longint span, v, t;
      if (lo > hi) begin
         t = lo; lo = hi; hi = t;
      end
      span = hi - lo + 1;
      case ($urandom_range(11))
         0: return int'($urandom);
         1: return int'(lo);
         2: return int'(hi);
         3: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         default: begin
            v = lo - span + longint'($urandom) % (3 * span);
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            return int'(v);
         end
      endcase
   endfunction

   task automatic add_random(int count);
      repeat (count) begin
         int x1, y1, x2, y2;
         x1 = pick_coord(win_x_min, win_x_max);
         y1 = pick_coord(win_y_min, win_y_max);
         x2 = $urandom_range(9) == 0 ? x1 : pick_coord(win_x_min, win_x_max);
         y2 = $urandom_range(9) == 0 ? y1 : pick_coord(win_y_min, win_y_max);
         add_seg(x1, y1, x2, y2);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_idle = 16; recv_idle = 52;
      add_seg(0, 0, 0, 0);
      add_seg(3 * ONE, 0, 3 * ONE, 0);
      add_seg(ONE / 2, -ONE / 4, -ONE / 3, ONE / 5);
      add_seg(-2 * ONE, 0, 2 * ONE, 0);
      add_seg(0, 3 * ONE, 0, -3 * ONE);
      add_seg(-3 * ONE, -3 * ONE, 3 * ONE, 3 * ONE);
      add_seg(3 * ONE, -3 * ONE, -3 * ONE, 3 * ONE);
      add_seg(-3 * ONE, -ONE, -2 * ONE, ONE);
      add_seg(2 * ONE, -ONE, 3 * ONE, ONE);
      add_seg(0, -5 * ONE, ONE, -2 * ONE);
      add_seg(0, 2 * ONE, ONE, 5 * ONE);
      add_seg(0, 3 * ONE, 3 * ONE, 0);
      add_seg(-3 * ONE, 0, 0, -3 * ONE);
      add_seg(ONE / 2, 3 * ONE, 3 * ONE / 2, -4 * ONE);
      add_seg(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
      add_seg(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
      add_seg(32'sh80000000, 5, 32'sh7fffffff, -7);
      add_seg(-ONE, -ONE, ONE, ONE);
      add_seg(ONE, ONE, ONE, ONE);
      add_seg(-ONE, 0, ONE + 1, 3);
      add_random(110);
      drain();

      set_window(-5 * ONE, 7 * ONE, -3 * ONE / 2, 4 * ONE);
      add_random(110);
      drain();

      send_idle = 52; recv_idle = 16;
      set_window(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
      add_random(100);
      drain();

      // Inverted window: x_min lies above x_max and y_min lies above y_max.
      set_window(2 * ONE, -2 * ONE, 3 * ONE, -ONE);
      add_random(100);
      drain();

      send_idle = 0; recv_idle = 0;
      set_window(7, 7, -3, -3);
      add_random(60);
      drain();

      set_window(-1000 * ONE, 20000 * ONE, -30000 * ONE, 77);
      add_random(150);
      drain();

      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> line_rectangle_clipper_top.f
rtl/lrc_pkg.sv
rtl/lrc_front.sv
rtl/lrc_fifo.sv
rtl/lrc_back.sv
rtl/line_rectangle_clipper_top.sv
tb/tb.sv
